>>> sv/lpts_pkg.sv
// shared types and constants of the look-ahead path tracking steer block
package lpts_pkg;

  // fixed field widths
  localparam int unsigned POS_W  = 24;
  localparam int unsigned QUAT_W = 16;
  localparam int unsigned DIST_W = 24;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned GIDX_W = 10;
  localparam int unsigned CFG_W  = 24;

  // squared distance and square root unit
  localparam int unsigned SQ_W       = 2 * POS_W;
  localparam int unsigned REM_W      = DIST_W + 2;
  localparam int unsigned ROOT_STEPS = SQ_W / 2;
  localparam int unsigned STEP_W     = $clog2(ROOT_STEPS);

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic CFG_LOOK_AHEAD = 1'b0;
  localparam logic CFG_K_POSITION = 1'b1;

  // configuration reset values
  localparam logic [DIST_W-1:0] LOOK_AHEAD_RST = 24'd12288;
  localparam logic [GAIN_W-1:0] K_POSITION_RST = 16'd2867;

  // one input item
  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic                     last_point;
  } lpts_in_t;

  // one result item
  typedef struct packed {
    logic signed [POS_W-1:0]  steer_rate;
    logic [GIDX_W-1:0]        goal_index;
    logic [DIST_W-1:0]        cross_track;
    logic [DIST_W-1:0]        dist_to_last;
    logic signed [POS_W-1:0]  goal_x;
    logic signed [POS_W-1:0]  goal_y;
    logic signed [QUAT_W-1:0] goal_qx;
    logic signed [QUAT_W-1:0] goal_qy;
    logic signed [QUAT_W-1:0] goal_qz;
    logic signed [QUAT_W-1:0] goal_qw;
    logic                     goal_found;
    logic                     index_overflow;
  } lpts_out_t;

  // pose of a path point
  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
  } lpts_pose_t;

  // queue entry: point plus its squared distance
  typedef struct packed {
    lpts_in_t          item;
    logic [SQ_W-1:0]   sq;
  } lpts_entry_t;

  // back end status toward the top level
  typedef struct packed {
    logic busy;
    logic load;
  } lpts_back_stat_t;

  function automatic lpts_pose_t lpts_to_pose(input lpts_in_t it);
    lpts_pose_t p;
    p.pos_x  = it.pos_x;
    p.pos_y  = it.pos_y;
    p.quat_x = it.quat_x;
    p.quat_y = it.quat_y;
    p.quat_z = it.quat_z;
    p.quat_w = it.quat_w;
    return p;
  endfunction

endpackage

>>> sv/lpts_front.sv
// front end: accepts path points and forms their squared distance
module lpts_front import lpts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  lpts_in_t    in_data_i,
  output logic        push_o,
  output lpts_entry_t push_entry_o,
  input  logic        push_ready_i
);

  logic                    vld_q;
  lpts_in_t                item_q;
  logic [SQ_W-1:0]         x2_q;
  logic [SQ_W-1:0]         y2_q;
  logic signed [SQ_W-1:0]  x2_s;
  logic signed [SQ_W-1:0]  y2_s;
  logic                    accept;

  // squares of both coordinates, registered before the sum
  assign x2_s = in_data_i.pos_x * in_data_i.pos_x;
  assign y2_s = in_data_i.pos_y * in_data_i.pos_y;

  // stage holds while the queue is full
  assign in_stall_o = vld_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // payload of the stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      x2_q   <= unsigned'(x2_s);
      y2_q   <= unsigned'(y2_s);
    end
  end

  // sum of squares goes into the queue
  assign push_o            = vld_q;
  assign push_entry_o.item = item_q;
  assign push_entry_o.sq   = x2_q + y2_q;

endmodule

>>> sv/lpts_queue.sv
// short queue between front and back end
module lpts_queue import lpts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lpts_entry_t       push_entry_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output lpts_entry_t       pop_entry_o,
  input  logic              pop_i,
  output logic [QCNT_W-1:0] count_o
);

  lpts_entry_t       slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              wr_en;
  logic              rd_en;

  assign push_ready_o = cnt_q < QCNT_W'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign wr_en        = push_i && push_ready_o;
  assign rd_en        = pop_i && pop_valid_o;
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign count_o      = cnt_q;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> sv/lpts_back.sv
// back end: square root, path tracking update and result register
module lpts_back import lpts_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  lpts_entry_t              q_entry_i,
  output logic                     q_pop_o,
  input  logic [DIST_W-1:0]        la_i,
  input  logic signed [GAIN_W-1:0] k_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output lpts_out_t                out_data_o,
  output lpts_back_stat_t          stat_o
);

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned ProdW = GAIN_W + POS_W;
  localparam int unsigned ShW = ProdW + 1 - 12;

  typedef enum logic [1:0] {ST_IDLE, ST_ROOT, ST_UPDATE} state_e;

  state_e              state_q;
  logic [STEP_W-1:0]   step_q;
  logic [SQ_W-1:0]     n_q;
  logic [REM_W-1:0]    rem_q;
  logic [DIST_W-1:0]   root_q;
  lpts_in_t            item_q;

  // per-path tracking state
  logic [CntW-1:0]     cnt_q;
  logic [DIST_W-1:0]   least_q;
  logic [DIST_W-1:0]   best_q;
  logic [GIDX_W-1:0]   cidx_q;
  lpts_pose_t          choice_q;
  logic                found_q;
  logic                ovf_q;

  logic                out_valid_q;
  lpts_out_t           out_q;

  // root step
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic [REM_W+1:0]    rem_sub;
  logic                ge;

  // update values
  logic [DIST_W-1:0]       least_n;
  logic [DIST_W-1:0]       diff;
  logic                    in_range;
  logic                    take_first;
  logic                    take_later;
  logic [CntW+GIDX_W-1:0]  idx_ext;
  lpts_pose_t              pose_n;
  logic [GIDX_W-1:0]       cidx_n;
  logic                    found_n;
  logic                    ovf_n;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW:0]   prod_r;
  logic [ShW-1:0]          prod_sh;
  logic [POS_W-1:0]        steer;
  logic                    out_free;
  logic                    do_update;
  logic                    load;

  // one result bit per step, two radicand bits consumed
  assign rem_sh  = {rem_q, n_q[SQ_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  // candidate selection on the finished distance
  assign least_n    = (root_q < least_q) ? root_q : least_q;
  assign diff       = (root_q >= la_i) ? (root_q - la_i) : (la_i - root_q);
  assign in_range   = cnt_q < CntW'(MAX_POINTS);
  assign take_first = in_range && (cnt_q == '0);
  assign take_later = in_range && (cnt_q != '0) && (!found_q || (diff < best_q));
  assign idx_ext    = {{GIDX_W{1'b0}}, cnt_q};
  assign pose_n     = (take_first || take_later) ? lpts_to_pose(item_q) : choice_q;
  assign cidx_n     = (take_first || take_later) ? idx_ext[GIDX_W-1:0] : cidx_q;
  assign found_n    = found_q || take_later;
  assign ovf_n      = ovf_q || !in_range;

  // steering: gain times goal y, round half up, saturate
  assign prod    = k_i * pose_n.pos_y;
  assign prod_r  = {prod[ProdW-1], prod} + (ProdW+1)'(2048);
  assign prod_sh = prod_r[ProdW:12];
  always_comb begin
    if ((&prod_sh[ShW-1:POS_W-1]) || !(|prod_sh[ShW-1:POS_W-1])) begin
      steer = prod_sh[POS_W-1:0];
    end else if (prod_sh[ShW-1]) begin
      steer = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      steer = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // a final point waits for a free result register
  assign out_free  = !out_valid_q || !out_stall_i;
  assign do_update = (state_q == ST_UPDATE) && (!item_q.last_point || out_free);
  assign load      = do_update && item_q.last_point;
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      n_q         <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      item_q      <= '0;
      cnt_q       <= '0;
      least_q     <= '1;
      best_q      <= '1;
      cidx_q      <= '0;
      choice_q    <= '0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // result register fills on a load, drains on a transfer
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            item_q  <= q_entry_i.item;
            n_q     <= q_entry_i.sq;
            rem_q   <= '0;
            root_q  <= '0;
            step_q  <= STEP_W'(ROOT_STEPS - 1);
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          rem_q  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
          root_q <= {root_q[DIST_W-2:0], ge};
          n_q    <= {n_q[SQ_W-3:0], 2'b00};
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (do_update) begin
            state_q <= ST_IDLE;
            if (item_q.last_point) begin
              out_q.steer_rate           <= steer;
              out_q.goal_index           <= cidx_n;
              out_q.cross_track          <= least_n;
              out_q.dist_to_last         <= root_q;
              out_q.goal_x               <= pose_n.pos_x;
              out_q.goal_y               <= pose_n.pos_y;
              out_q.goal_qx              <= pose_n.quat_x;
              out_q.goal_qy              <= pose_n.quat_y;
              out_q.goal_qz              <= pose_n.quat_z;
              out_q.goal_qw              <= pose_n.quat_w;
              out_q.goal_found           <= found_n;
              out_q.index_overflow       <= ovf_n;
              // fresh path
              cnt_q    <= '0;
              least_q  <= '1;
              best_q   <= '1;
              cidx_q   <= '0;
              choice_q <= '0;
              found_q  <= 1'b0;
              ovf_q    <= 1'b0;
            end else begin
              cnt_q    <= in_range ? (cnt_q + 1'b1) : cnt_q;
              least_q  <= least_n;
              best_q   <= take_later ? diff : best_q;
              cidx_q   <= cidx_n;
              choice_q <= pose_n;
              found_q  <= found_n;
              ovf_q    <= ovf_n;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign stat_o.busy = state_q != ST_IDLE;
  assign stat_o.load = load;

endmodule

>>> sv/lookahead_path_tracking_steer.sv
// Look-ahead path tracking steer: top level with configuration registers.
//
// Path points enter on the input channel (in_valid_i, in_stall_o, in_data_i),
// one per transfer, in vehicle frame; last_point marks the end of a path.
// On the final point one result leaves on the output channel (out_valid_o,
// out_stall_i, out_data_o): steering command, goal index and pose,
// cross-track error, distance of the final point and status flags.
// Configuration (look-ahead distance, gain) is to be written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i only while no path point is in flight; the block
// itself does not enforce this. The back end takes one point at a time: a
// load, the square root unit's 24 one-bit steps and an update, and it takes
// no new point before that update is done.
// A two-entry queue sits between the front end, which squares the
// coordinates, and the back end, so points keep being taken while a result
// waits. With the receiver stalling, the result register holds, the back end
// stops before its next final point and the queue fills, then in_stall_o rises.
// Reset clears the path state and loads the default configuration.
module lookahead_path_tracking_steer import lpts_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lpts_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lpts_out_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic [DIST_W-1:0]        la_q;
  logic signed [GAIN_W-1:0] k_q;

  logic              push;
  lpts_entry_t       push_entry;
  logic              push_ready;
  logic              q_valid;
  lpts_entry_t       q_entry;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;
  lpts_back_stat_t   bstat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q <= LOOK_AHEAD_RST;
      k_q  <= K_POSITION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOOK_AHEAD: la_q <= cfg_wdata_i[DIST_W-1:0];
        CFG_K_POSITION: k_q  <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  lpts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  lpts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_entry_o  (q_entry),
    .pop_i        (q_pop),
    .count_o      (q_count)
  );

  lpts_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .la_i        (la_q),
    .k_i         (k_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .stat_o      (bstat)
  );

`ifndef ASSERT_OFF
  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(QDEPTH))
    else $error("queue fill level beyond depth");

  // back end pops only from a non-empty queue and then works on the point
  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_count != '0) ##1 bstat.busy)
    else $error("pop from empty queue or back end not busy after pop");

  // a result is never loaded over one that waits
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.load |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

  // a result shows up only after a final point was finished
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bstat.load))
    else $error("result without a finished final point");
`endif

endmodule
